// ===== rtl/fss_pkg.sv =====
// shared types, constants and weight table for the fair share scheduler
`default_nettype none
package fss_pkg;

    localparam int MAX_TASKS     = 16;
    localparam int IDX_W         = $clog2(MAX_TASKS);
    localparam int CNT_W         = $clog2(MAX_TASKS + 1);
    localparam int VRT_FRAC_BITS = 16;
    localparam int VRT_W         = 48;
    localparam int WGT_W         = 17;
    localparam int WSUM_W        = 21;
    localparam int TIME_W        = 16;
    localparam int NUM_W         = 10 + TIME_W + VRT_FRAC_BITS;
    localparam int SLC_NUM_W     = WGT_W + TIME_W;
    localparam int DIV_N_W       = (NUM_W > SLC_NUM_W) ? NUM_W : SLC_NUM_W;
    localparam int DIV_D_W       = WSUM_W;
    localparam int DIV_CNT_W     = $clog2(DIV_N_W + 1);

    localparam logic [1:0] REG_LATENCY = 2'd0;
    localparam logic [1:0] REG_MINGRAN = 2'd1;
    localparam logic [1:0] REG_TCOUNT  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_SLICE_MUL,
        ST_SLICE_DIV,
        ST_RUN,
        ST_VRT_DIV,
        ST_UPDATE,
        ST_DONE_ALL,
        ST_LOAD
    } fss_state_t;

    typedef struct packed {
        logic scan_clear;
        logic scan_step;
        logic load_wr;
        logic slice_mul;
        logic div_start_slice;
        logic div_start_vrt;
        logic run_calc;
        logic update;
        logic emit_step;
        logic emit_all_done;
    } fss_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic div_busy;
    } fss_stat_t;

    function automatic logic [WGT_W-1:0] weight_of_nice(input logic signed [5:0] nice);
        logic [5:0] k;
        logic [WGT_W-1:0] w;
        k = 6'd0;
        if (nice < -6'sd20)
            k = 6'd0;
        else if (nice > 6'sd19)
            k = 6'd39;
        else
            k = 6'(nice + 6'sd20);
        case (k)
            6'd0:  w = 17'd88761;  6'd1:  w = 17'd71755;  6'd2:  w = 17'd56483;
            6'd3:  w = 17'd46273;  6'd4:  w = 17'd36291;  6'd5:  w = 17'd29154;
            6'd6:  w = 17'd23254;  6'd7:  w = 17'd18705;  6'd8:  w = 17'd14949;
            6'd9:  w = 17'd11916;  6'd10: w = 17'd9548;   6'd11: w = 17'd7620;
            6'd12: w = 17'd6100;   6'd13: w = 17'd4904;   6'd14: w = 17'd3906;
            6'd15: w = 17'd3121;   6'd16: w = 17'd2501;   6'd17: w = 17'd1991;
            6'd18: w = 17'd1586;   6'd19: w = 17'd1277;   6'd20: w = 17'd1024;
            6'd21: w = 17'd820;    6'd22: w = 17'd655;    6'd23: w = 17'd526;
            6'd24: w = 17'd423;    6'd25: w = 17'd335;    6'd26: w = 17'd272;
            6'd27: w = 17'd215;    6'd28: w = 17'd172;    6'd29: w = 17'd137;
            6'd30: w = 17'd110;    6'd31: w = 17'd87;     6'd32: w = 17'd70;
            6'd33: w = 17'd56;     6'd34: w = 17'd45;     6'd35: w = 17'd36;
            6'd36: w = 17'd29;     6'd37: w = 17'd23;     6'd38: w = 17'd18;
            default: w = 17'd15;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fss_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module fss_divider
    import fss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_N_W-1:0] dividend,
    input  wire logic [DIV_D_W-1:0] divisor,
    output logic                    busy,
    output logic [DIV_N_W-1:0]      quotient
);
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W:0]     rem_reg, rem_next;
    logic [DIV_D_W-1:0]   den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DIV_D_W:0]     trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DIV_D_W-1:0], quo_reg[DIV_N_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== rtl/fss_datapath.sv =====
// task tables, minimum scan, slice and runtime arithmetic
`default_nettype none
module fss_datapath
    import fss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fss_cmd_t          cmd,
    output fss_stat_t              stat,
    input  wire logic [IDX_W-1:0]  in_index,
    input  wire logic [TIME_W-1:0] in_burst,
    input  wire logic signed [5:0] in_nice,
    input  wire logic [TIME_W-1:0] latency,
    input  wire logic [TIME_W-1:0] min_gran,
    input  wire logic [CNT_W-1:0]  n_active,
    output logic [IDX_W-1:0]       chosen_task,
    output logic [TIME_W-1:0]      run_length,
    output logic                   task_done,
    output logic                   all_done
);
    logic [WGT_W-1:0]  wgt_mem [MAX_TASKS];
    logic [TIME_W-1:0] rem_mem [MAX_TASKS];
    logic [VRT_W-1:0]  vrt_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] fin_reg;
    logic [MAX_TASKS-1:0] loaded_reg;
    logic [WSUM_W-1:0] wsum_reg;

    logic [IDX_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  best_reg;
    logic [VRT_W-1:0]  bestv_reg;
    logic              found_reg;
    logic [WGT_W-1:0]  w_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [VRT_W-1:0]  v_reg;
    logic [SLC_NUM_W-1:0] prod_reg;
    logic [TIME_W-1:0] run_reg;
    logic              tdone_reg;
    logic [IDX_W-1:0]  out_task_reg;
    logic [TIME_W-1:0] out_run_reg;
    logic              out_tdone_reg;
    logic              out_all_reg;

    logic              div_start;
    logic [DIV_N_W-1:0] div_dvd;
    logic [DIV_D_W-1:0] div_dvs;
    logic              div_busy;
    logic [DIV_N_W-1:0] div_q;
    logic [WGT_W-1:0]  new_w;
    logic [WGT_W-1:0]  old_w;
    logic [VRT_W:0]    vsum;
    logic [TIME_W-1:0] slice;
    logic [MAX_TASKS-1:0] act_mask;
    logic [MAX_TASKS-1:0] fin_after;

    assign new_w = weight_of_nice(in_nice);
    assign old_w = loaded_reg[in_index] ? wgt_mem[in_index] : '0;
    assign div_start = cmd.div_start_slice | cmd.div_start_vrt;

    always_comb
    begin
        div_dvd = '0;
        div_dvs = '0;
        if (cmd.div_start_slice)
        begin
            div_dvd = DIV_N_W'(prod_reg);
            div_dvs = wsum_reg;
        end
        else
        begin
            div_dvd = DIV_N_W'({run_reg, 10'd0, {VRT_FRAC_BITS{1'b0}}});
            div_dvs = DIV_D_W'(w_reg);
        end
    end

    fss_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        slice = min_gran;
        if (wsum_reg != '0)
        begin
            if (div_q[DIV_N_W-1:TIME_W] != '0)
                slice = '1;
            else if (div_q[TIME_W-1:0] > min_gran)
                slice = div_q[TIME_W-1:0];
        end
    end

    // active slots and finish marks after the current step
    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
            act_mask[i] = (CNT_W'(i) < n_active);
    end

    assign fin_after = fin_reg | (tdone_reg ? (MAX_TASKS'(1) << best_reg) : '0);

    assign vsum = {1'b0, v_reg} + (w_reg == '0 ? '0 : (VRT_W+1)'(div_q[NUM_W-1:0]));

    assign stat.scan_last = ({1'b0, scan_reg} == n_active - 1'b1);
    assign stat.found     = found_reg;
    assign stat.div_busy  = div_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg    <= '0;
            loaded_reg <= '0;
            wsum_reg   <= '0;
            for (int i = 0; i < MAX_TASKS; i++)
                vrt_mem[i] <= '0;
        end
        else
        begin
            if (cmd.load_wr)
            begin
                wsum_reg <= wsum_reg - WSUM_W'(old_w) + WSUM_W'(new_w);
                loaded_reg[in_index] <= 1'b1;
                vrt_mem[in_index] <= '0;
                if (fin_reg[in_index])
                    fin_reg[in_index] <= 1'b0;
            end
            if (cmd.update)
            begin
                vrt_mem[best_reg] <= vsum[VRT_W] ? '1 : vsum[VRT_W-1:0];
                if (tdone_reg)
                    fin_reg[best_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            wgt_mem[in_index] <= new_w;
            rem_mem[in_index] <= in_burst;
        end
        if (cmd.update)
            rem_mem[best_reg] <= rem_reg - run_reg;
        if (cmd.scan_clear)
        begin
            scan_reg  <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (!fin_reg[scan_reg] && (!found_reg || vrt_mem[scan_reg] < bestv_reg))
            begin
                best_reg  <= scan_reg;
                bestv_reg <= vrt_mem[scan_reg];
                found_reg <= 1'b1;
            end
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.slice_mul)
        begin
            w_reg    <= wgt_mem[best_reg];
            rem_reg  <= rem_mem[best_reg];
            v_reg    <= vrt_mem[best_reg];
            prod_reg <= wgt_mem[best_reg] * latency;
        end
        if (cmd.run_calc)
        begin
            run_reg   <= (slice < rem_reg) ? slice : rem_reg;
            tdone_reg <= (slice >= rem_reg);
        end
        if (cmd.emit_step)
        begin
            out_task_reg  <= best_reg;
            out_run_reg   <= run_reg;
            out_tdone_reg <= tdone_reg;
            out_all_reg   <= &(fin_after | ~act_mask);
        end
        else if (cmd.emit_all_done)
        begin
            out_task_reg  <= '0;
            out_run_reg   <= '0;
            out_tdone_reg <= 1'b0;
            out_all_reg   <= 1'b1;
        end
    end

    assign chosen_task = out_task_reg;
    assign run_length  = out_run_reg;
    assign task_done   = out_tdone_reg;
    assign all_done    = out_all_reg;
endmodule
`default_nettype wire

// ===== rtl/fss_control.sv =====
// sequencing state machine for loads and scheduling steps
`default_nettype none
module fss_control
    import fss_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      mode,
    input  wire logic      load_ok,
    input  wire fss_stat_t stat,
    output fss_cmd_t       cmd,
    output logic           busy,
    output logic           result_valid
);
    fss_state_t state_reg, state_next;
    logic       valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (!mode)
                        state_next = ST_LOAD;
                    else
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_wr = load_ok;
                state_next  = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (stat.found)
                begin
                    cmd.slice_mul = 1'b1;
                    state_next    = ST_SLICE_MUL;
                end
                else
                begin
                    cmd.emit_all_done = 1'b1;
                    valid_next        = 1'b1;
                    state_next        = ST_DONE_ALL;
                end
            end
            ST_SLICE_MUL:
            begin
                cmd.div_start_slice = 1'b1;
                state_next          = ST_SLICE_DIV;
            end
            ST_SLICE_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.run_calc = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.div_start_vrt = 1'b1;
                state_next        = ST_VRT_DIV;
            end
            ST_VRT_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.update    = 1'b1;
                    cmd.emit_step = 1'b1;
                    valid_next    = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE:   state_next = ST_IDLE;
            ST_DONE_ALL: state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
endmodule
`default_nettype wire

// ===== rtl/fair_share_scheduler_step.sv =====
// top level of the fair share scheduler step engine
`default_nettype none
// A load request keeps busy high for one cycle after acceptance. A step request
// keeps busy high through a minimum scan over the n active tasks, two passes of a
// shared radix-2 divider at one quotient bit per cycle (slice and runtime
// increment), and the setup and update states. When every task is already finished
// a step ends after the scan without any divider pass.
// The result appears on the result ports for one cycle, marked by done, in the
// last busy cycle; it cannot be stalled. Busy drops in the cycle after the result.
module fair_share_scheduler_step
    import fss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              mode,
    input  wire logic [3:0]        task_index,
    input  wire logic [15:0]       burst,
    input  wire logic signed [5:0] nice_level,
    output logic                   done,
    output logic [3:0]             chosen_task,
    output logic [15:0]            run_length,
    output logic                   task_done,
    output logic                   all_done
);
    logic [TIME_W-1:0] latency_reg;
    logic [TIME_W-1:0] mingran_reg;
    logic [4:0]        tcount_reg;
    logic [CNT_W-1:0]  n_active;
    logic              idx_reg;
    logic [IDX_W-1:0]  lidx_reg;
    logic [TIME_W-1:0] lburst_reg;
    logic signed [5:0] lnice_reg;
    logic              lmode_reg;
    logic              load_ok;
    logic              accept;
    fss_cmd_t          cmd;
    fss_stat_t         stat;

    assign pready = 1'b1;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latency_reg <= 16'd48;
            mingran_reg <= 16'd6;
            tcount_reg  <= 5'd1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_LATENCY: latency_reg <= pwdata[15:0];
                REG_MINGRAN: mingran_reg <= pwdata[15:0];
                REG_TCOUNT:  tcount_reg  <= pwdata[4:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LATENCY: prdata = {16'd0, latency_reg};
            REG_MINGRAN: prdata = {16'd0, mingran_reg};
            REG_TCOUNT:  prdata = {27'd0, tcount_reg};
            default:     prdata = '0;
        endcase
    end

    always_comb
    begin
        if (tcount_reg == '0)
            n_active = CNT_W'(1);
        else if ({1'b0, tcount_reg} > 6'(MAX_TASKS))
            n_active = CNT_W'(MAX_TASKS);
        else
            n_active = CNT_W'(tcount_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lidx_reg   <= task_index;
            lburst_reg <= burst;
            lnice_reg  <= nice_level;
            lmode_reg  <= mode;
        end
    end

    assign idx_reg = lmode_reg;
    assign load_ok = ({1'b0, lidx_reg} < n_active) & ~idx_reg;

    fss_control u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .mode         (mode),
        .load_ok      (load_ok),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (done)
    );

    fss_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_index    (lidx_reg),
        .in_burst    (lburst_reg),
        .in_nice     (lnice_reg),
        .latency     (latency_reg),
        .min_gran    (mingran_reg),
        .n_active    (n_active),
        .chosen_task (chosen_task),
        .run_length  (run_length),
        .task_done   (task_done),
        .all_done    (all_done)
    );

`ifndef SYNTH
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a request");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_no_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !mode) |=> ##1 !done)
        else $error("load produced a result");
    a_all_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && all_done && !task_done) |-> run_length == '0)
        else $error("all done result carries a run");
`endif
endmodule
`default_nettype wire

// ===== test/fair_share_scheduler_step_tb.sv =====
// testbench for the fair share scheduler step engine with a built-in scheduling predictor
module fair_share_scheduler_step_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fss_pkg::*;

    typedef struct {
        logic        mode;
        logic [3:0]  idx;
        logic [15:0] burst;
        logic [5:0]  nice;
    } sched_req_t;

    typedef struct {
        logic [3:0]  task_id;
        logic [15:0] run;
        logic        tdone;
        logic        adone;
    } step_outcome_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int NUM_PHASES     = 10;

    localparam int nice_weight[40] = '{
        88761, 71755, 56483, 46273, 36291, 29154, 23254, 18705, 14949, 11916,
        9548, 7620, 6100, 4904, 3906, 3121, 2501, 1991, 1586, 1277,
        1024, 820, 655, 526, 423, 335, 272, 215, 172, 137,
        110, 87, 70, 56, 45, 36, 29, 23, 18, 15
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic        mode = 1'b0;
    logic [3:0]  task_index = '0;
    logic [15:0] burst = '0;
    logic signed [5:0] nice_level = '0;
    logic        done;
    logic [3:0]  chosen_task;
    logic [15:0] run_length;
    logic        task_done;
    logic        all_done;

    fair_share_scheduler_step u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .task_index (task_index),
        .burst      (burst),
        .nice_level (nice_level),
        .done       (done),
        .chosen_task(chosen_task),
        .run_length (run_length),
        .task_done  (task_done),
        .all_done   (all_done)
    );

    always #6 clk = ~clk;

    sched_req_t    pending_reqs[$];
    step_outcome_t expected_steps[$];
    int            accepted_cnt = 0;
    int            taken_cnt = 0;
    int            idle_pct = 0;
    int            errors = 0;
    int            quiet_cycles = 0;
    bit            slot_loaded[16];

    logic [16:0] sim_weight[16];
    logic [15:0] sim_remain[16];
    logic [47:0] sim_vruntime[16];
    logic        sim_finished[16];
    logic [20:0] sim_weight_sum;
    logic [4:0]  sim_finished_cnt;
    logic [15:0] sim_latency;
    logic [15:0] sim_min_gran;
    logic [4:0]  sim_task_count;

    function automatic int active_tasks();
        int n;
        n = sim_task_count;
        if (n < 1)
            n = 1;
        if (n > MAX_TASKS)
            n = MAX_TASKS;
        return n;
    endfunction

    task automatic schedule_request(input sched_req_t r);
        int            n;
        int            best;
        int            nv;
        bit            found;
        logic [16:0]   w;
        logic [63:0]   slice;
        logic [63:0]   inc;
        logic [63:0]   v;
        logic [15:0]   run;
        step_outcome_t o;
        n = active_tasks();
        if (!r.mode) begin
            if (r.idx >= n)
                return;
            nv = $signed(r.nice);
            if (nv < -20)
                nv = -20;
            if (nv > 19)
                nv = 19;
            w = 17'(nice_weight[nv + 20]);
            sim_weight_sum = sim_weight_sum - 21'(sim_weight[r.idx]) + 21'(w);
            sim_weight[r.idx] = w;
            sim_remain[r.idx] = r.burst;
            sim_vruntime[r.idx] = '0;
            if (sim_finished[r.idx]) begin
                sim_finished[r.idx] = 1'b0;
                sim_finished_cnt = sim_finished_cnt - 5'd1;
            end
            return;
        end
        best = 0;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!sim_finished[i] && (!found || sim_vruntime[i] < sim_vruntime[best])) begin
                best = i;
                found = 1'b1;
            end
        end
        o = '{task_id: 4'd0, run: 16'd0, tdone: 1'b0, adone: 1'b1};
        if (found) begin
            w = sim_weight[best];
            slice = 64'd0;
            if (sim_weight_sum != 0)
                slice = (64'(w) * 64'(sim_latency)) / 64'(sim_weight_sum);
            if (slice < 64'(sim_min_gran))
                slice = 64'(sim_min_gran);
            if (slice > 64'hFFFF)
                slice = 64'hFFFF;
            run = sim_remain[best];
            if (slice < 64'(run))
                run = 16'(slice);
            sim_remain[best] = sim_remain[best] - run;
            inc = 64'd0;
            if (w != 0)
                inc = ((64'd1024 * 64'(run)) << VRT_FRAC_BITS) / 64'(w);
            v = 64'(sim_vruntime[best]);
            if (inc > 64'hFFFF_FFFF_FFFF - v)
                v = 64'hFFFF_FFFF_FFFF;
            else
                v = v + inc;
            sim_vruntime[best] = 48'(v);
            o.tdone = 1'b0;
            if (sim_remain[best] == 0) begin
                sim_finished[best] = 1'b1;
                sim_finished_cnt = sim_finished_cnt + 5'd1;
                o.tdone = 1'b1;
            end
            o.task_id = 4'(best);
            o.run = run;
            o.adone = 1'b1;
            for (int i = 0; i < n; i++)
                if (!sim_finished[i])
                    o.adone = 1'b0;
        end
        expected_steps.push_back(o);
    endtask

    task automatic check_field(input string nm, input longint e, input longint g);
        if (e != g) begin
            errors++;
            $display("%0t mismatch %s expected %0d actual %0d", $realtime, nm, e, g);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LATENCY: sim_latency = value[15:0];
            REG_MINGRAN: sim_min_gran = value[15:0];
            REG_TCOUNT:  sim_task_count = value[4:0];
            default: ;
        endcase
    endtask

    task automatic queue_load(input int idx, input logic [15:0] b, input logic [5:0] nv);
        pending_reqs.push_back('{mode: 1'b0, idx: 4'(idx), burst: b, nice: nv});
        if (idx < active_tasks())
            slot_loaded[idx] = 1'b1;
    endtask

    task automatic queue_step();
        pending_reqs.push_back('{mode: 1'b1, idx: 4'($urandom), burst: 16'($urandom),
                                 nice: 6'($urandom)});
    endtask

    function automatic logic [15:0] rand_burst();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 120));
    endfunction

    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || start || expected_steps.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver: one request held on the ports until accepted
    always @(negedge clk) begin
        bit go;
        bit held;
        if (rst_n) begin
            held = start && accepted_cnt == taken_cnt;
            if (start && accepted_cnt != taken_cnt) begin
                void'(pending_reqs.pop_front());
                taken_cnt++;
            end
            if (!held) begin
                go = pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct;
                if (go) begin
                    mode <= pending_reqs[0].mode;
                    task_index <= pending_reqs[0].idx;
                    burst <= pending_reqs[0].burst;
                    nice_level <= pending_reqs[0].nice;
                end
                start <= go;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk) begin
        step_outcome_t e;
        bit seen;
        seen = 1'b0;
        if (rst_n && start && !busy) begin
            schedule_request('{mode: mode, idx: task_index, burst: burst, nice: nice_level});
            accepted_cnt++;
            seen = 1'b1;
        end
        if (rst_n && done) begin
            seen = 1'b1;
            if (expected_steps.size() == 0) begin
                errors++;
                $display("%0t unexpected result task %0d run %0d", $realtime, chosen_task,
                         run_length);
            end
            else begin
                e = expected_steps.pop_front();
                check_field("chosen_task", e.task_id, chosen_task);
                check_field("run_length", e.run, run_length);
                check_field("task_done", e.tdone, task_done);
                check_field("all_done", e.adone, all_done);
            end
        end
        quiet_cycles = seen ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    localparam int phase_lat[NUM_PHASES]  = '{65535, 0, 0, 1000, 48, 65535, 7, -1, -1, -1};
    localparam int phase_gran[NUM_PHASES] = '{0, 0, 65535, 3, 6, 65535, 1, -1, -1, -1};
    localparam int phase_cnt[NUM_PHASES]  = '{16, 3, 2, 31, 0, 7, 16, -1, -1, -1};

    initial begin
        int n;
        int cnt;
        int r;
        for (int i = 0; i < 16; i++) begin
            sim_weight[i] = '0;
            sim_remain[i] = '0;
            sim_vruntime[i] = '0;
            sim_finished[i] = 1'b0;
        end
        sim_weight_sum = '0;
        sim_finished_cnt = '0;
        sim_latency = 16'd48;
        sim_min_gran = 16'd6;
        sim_task_count = 5'd1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed: nice extremes, zero and full burst, ignored load, reload, all finished
        write_reg(REG_TCOUNT, 32'd4);
        queue_load(0, 16'd0, 6'b100000);
        queue_load(1, 16'hFFFF, 6'b011111);
        queue_load(2, 16'd10, 6'(-20));
        queue_load(3, 16'd1, 6'd19);
        queue_load(3, 16'd2, 6'd0);
        pending_reqs.push_back('{mode: 1'b0, idx: 4'd9, burst: 16'd5, nice: 6'd1});
        repeat (5) queue_step();
        queue_load(1, 16'd3, 6'd0);
        repeat (6) queue_step();
        wait_quiet();

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 52 : 35;
            write_reg(REG_LATENCY, phase_lat[p] < 0 ? $urandom_range(0, 65535) : phase_lat[p]);
            write_reg(REG_MINGRAN,
                      phase_gran[p] < 0 ? $urandom_range(0, 40) : phase_gran[p]);
            write_reg(REG_TCOUNT, phase_cnt[p] < 0 ? $urandom_range(0, 31) : phase_cnt[p]);
            n = active_tasks();
            for (int i = 0; i < n; i++)
                if (!slot_loaded[i] || $urandom_range(0, 1) == 1)
                    queue_load(i, rand_burst(), 6'($urandom_range(0, 63)));
            cnt = 0;
            while (cnt < 100) begin
                r = $urandom_range(0, 99);
                if (r < 72) begin
                    queue_step();
                    cnt++;
                end
                else if (r < 92) begin
                    queue_load($urandom_range(0, n - 1), rand_burst(),
                               6'($urandom_range(0, 63)));
                    cnt++;
                end
                else if (n < 16)
                    pending_reqs.push_back('{mode: 1'b0, idx: 4'($urandom_range(n, 15)),
                                             burst: 16'($urandom), nice: 6'($urandom)});
            end
            wait_quiet();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
